[hdl/lpvc_pkg.sv]
// ----------------------------------------------------------------------------
// Line-probed value cache package
// Shared widths, status codes, defaults and the probe result type.
// ----------------------------------------------------------------------------
`default_nettype none

package lpvc_pkg;

  // Field widths
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CFG_W  = 4;
  // Width of an effective size exponent (up to the largest table depth)
  localparam int unsigned SZ_W   = 5;

  // Parameter defaults
  localparam int unsigned DEF_LOG2_MAX_ENTRIES = 12;
  localparam int unsigned DEF_LINE_ENTRIES     = 16;

  // Register reset value
  localparam logic [CFG_W-1:0] SIZE_LOG2_RESET = 4'd12;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_PRESENT  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_REPLACED = 3'd2;
  localparam logic [STAT_W-1:0] STAT_CLEARED  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd4;

  // Outcome of one line probe
  typedef struct packed {
    logic              we;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  old_value;
  } lpvc_res_t;

endpackage

`default_nettype wire

[hdl/lpvc_line_ram.sv]
// ----------------------------------------------------------------------------
// Line RAM
// One line of slots per row; one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lpvc_line_ram import lpvc_pkg::*; #(
  parameter int unsigned ROW_AW = 8,
  parameter int unsigned ROWS   = 256,
  parameter int unsigned LINE_W = 512
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ROW_AW-1:0] waddr_i,
  input  logic [LINE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ROW_AW-1:0] raddr_i,
  output logic [LINE_W-1:0] rdata_o
);

  logic [LINE_W-1:0] mem [ROWS];
  logic [LINE_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/lpvc_probe.sv]
// ----------------------------------------------------------------------------
// Line probe
// Compares every slot of a line at once, picks the first hit in wrap order
// from the start slot and builds the line to write back.
// ----------------------------------------------------------------------------
`default_nettype none

module lpvc_probe import lpvc_pkg::*; #(
  parameter int unsigned LOG2_LINE = 4
) (
  input  logic [(1<<LOG2_LINE)*VAL_W-1:0] line_i,
  input  logic                            func_i,
  input  logic                            range_err_i,
  input  logic [LOG2_LINE-1:0]            off_i,
  input  logic [VAL_W-1:0]                value_i,
  output logic [(1<<LOG2_LINE)*VAL_W-1:0] line_o,
  output lpvc_res_t                       res_o
);

  localparam int unsigned LINE = 1 << LOG2_LINE;

  logic [VAL_W-1:0]     slot [LINE];
  logic [LINE-1:0]      match;
  logic                 found;
  logic [LOG2_LINE-1:0] hit_idx;

  // Unpack slots; a slot matches when empty or equal to the value
  for (genvar j = 0; j < LINE; j++) begin : g_slot
    assign slot[j]  = line_i[j*VAL_W +: VAL_W];
    assign match[j] = (slot[j] == '0) || (slot[j] == value_i);
  end

  // First match in probe order, wrapping within the line
  always_comb begin : p_find
    logic [LOG2_LINE-1:0] idx;
    found   = 1'b0;
    hit_idx = off_i;
    for (int k = 0; k < LINE; k++) begin
      idx = off_i + LOG2_LINE'(k);
      if (!found && match[idx]) begin
        found   = 1'b1;
        hit_idx = idx;
      end
    end
  end

  // Result and write-back line
  always_comb begin
    line_o          = line_i;
    res_o.we        = 1'b0;
    res_o.status    = STAT_PRESENT;
    res_o.old_value = '0;
    if (func_i) begin
      if (range_err_i) begin
        res_o.status = STAT_RANGE;
      end else begin
        res_o.we                      = 1'b1;
        res_o.status                  = STAT_CLEARED;
        res_o.old_value               = slot[off_i];
        line_o[off_i*VAL_W +: VAL_W] = '0;
      end
    end else if (found) begin
      if (slot[hit_idx] == '0) begin
        res_o.we                        = 1'b1;
        res_o.status                    = STAT_INSERTED;
        line_o[hit_idx*VAL_W +: VAL_W] = value_i;
      end
    end else begin
      // line full: evict the start slot
      res_o.we                      = 1'b1;
      res_o.status                  = STAT_REPLACED;
      res_o.old_value               = slot[off_i];
      line_o[off_i*VAL_W +: VAL_W] = value_i;
    end
  end

endmodule

`default_nettype wire

[hdl/line_probed_value_cache_top.sv]
// ----------------------------------------------------------------------------
// Line-probed value cache, top level
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one transaction: func_i
//    selects a put (value_i, hash_i) or a clear of entry_index_i.
//  - Output channel (out_valid_o/out_ready_i) returns one transaction per
//    input: status_o and old_value_o.
//  - cfg_we_i/cfg_wdata_i write size_log2; write it only while idle.
//  - A put reads the whole line holding its start slot, compares all slots
//    in parallel and writes the line back if it changed; a clear does the
//    same for one slot. The line RAM read/modify/write sets the rate.
//  - The RAM read is registered on acceptance and the result is registered
//    into the output register from ST_EVAL, which holds while the output
//    register is full; a new transaction is taken only back in ST_IDLE.
//  - Reset: a clearing pass zeroes the RAM one line per cycle, covering
//    all 2**LOG2_MAX_ENTRIES / LINE_ENTRIES lines (256 with the defaults);
//    in_ready_o stays low meanwhile.
//  - Receiver stall: one result waits in the output register while the next
//    transaction is accepted and read; that one then holds until the output
//    register frees. User must keep LINE_ENTRIES a power of two; unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module line_probed_value_cache_top import lpvc_pkg::*; #(
  parameter int unsigned LOG2_MAX_ENTRIES = DEF_LOG2_MAX_ENTRIES,
  parameter int unsigned LINE_ENTRIES     = DEF_LINE_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [VAL_W-1:0]  value_i,
  input  logic [HASH_W-1:0] hash_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic [VAL_W-1:0]  old_value_o,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  localparam int unsigned LOG2_LINE     = $clog2(LINE_ENTRIES);
  // A line wider than the table aliases onto the whole table
  localparam int unsigned LOG2_LINE_EFF =
    (LOG2_LINE > LOG2_MAX_ENTRIES) ? LOG2_MAX_ENTRIES : LOG2_LINE;
  localparam int unsigned LINE_W        = (1 << LOG2_LINE_EFF) * VAL_W;
  localparam int unsigned ROW_BITS      = LOG2_MAX_ENTRIES - LOG2_LINE_EFF;
  localparam int unsigned ROW_AW        = (ROW_BITS > 0) ? ROW_BITS : 1;
  localparam int unsigned ROWS          = 1 << ROW_BITS;
  localparam int unsigned AW            = LOG2_MAX_ENTRIES;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [ROW_AW-1:0]       clr_cnt_q;
  logic [CFG_W-1:0]        size_log2_q;
  logic [SZ_W-1:0]         sz_cap, sz;
  logic [AW-1:0]           start_addr, clr_addr, sel_addr;
  logic [ROW_AW-1:0]       rd_row;
  logic                    range_err;
  logic                    in_acc, out_free, eval_fire;
  logic                    func_q, range_q;
  logic [VAL_W-1:0]        value_q;
  logic [LOG2_LINE_EFF-1:0] off_q;
  logic [ROW_AW-1:0]       row_q;
  logic                    mem_we;
  logic [ROW_AW-1:0]       mem_waddr;
  logic [LINE_W-1:0]       mem_wdata, rd_line, new_line;
  lpvc_res_t               res;
  logic                    out_valid_q;
  logic [STAT_W-1:0]       status_q;
  logic [VAL_W-1:0]        old_value_q;

  // Size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= SIZE_LOG2_RESET;
    end else if (cfg_we_i) begin
      size_log2_q <= cfg_wdata_i;
    end
  end

  // Effective size exponent: capped at the table, raised to one line
  assign sz_cap = (SZ_W'(size_log2_q) > SZ_W'(LOG2_MAX_ENTRIES)) ?
                  SZ_W'(LOG2_MAX_ENTRIES) : SZ_W'(size_log2_q);
  assign sz     = (sz_cap < SZ_W'(LOG2_LINE)) ? SZ_W'(LOG2_LINE) : sz_cap;

  // Address of the incoming transaction
  assign start_addr = AW'(hash_i) & ~({AW{1'b1}} << sz);
  assign clr_addr   = AW'(entry_index_i);
  assign range_err  = |(entry_index_i >> sz);
  assign sel_addr   = func_i ? clr_addr : start_addr;
  assign rd_row     = ROW_AW'(32'(sel_addr) >> LOG2_LINE_EFF);

  // Handshake
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign eval_fire   = (state_q == ST_EVAL) && out_free;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == ROW_AW'(ROWS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + ROW_AW'(1);
    end
  end

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q  <= func_i;
      range_q <= range_err;
      value_q <= value_i;
      off_q   <= sel_addr[LOG2_LINE_EFF-1:0];
      row_q   <= rd_row;
    end
  end

  // Line storage
  lpvc_line_ram #(
    .ROW_AW (ROW_AW),
    .ROWS   (ROWS),
    .LINE_W (LINE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_acc),
    .raddr_i (rd_row),
    .rdata_o (rd_line)
  );

  // Probe and modify
  lpvc_probe #(
    .LOG2_LINE (LOG2_LINE_EFF)
  ) u_probe (
    .line_i      (rd_line),
    .func_i      (func_q),
    .range_err_i (range_q),
    .off_i       (off_q),
    .value_i     (value_q),
    .line_o      (new_line),
    .res_o       (res)
  );

  // Write back, or clearing pass after reset
  assign mem_we    = (state_q == ST_CLEAR) || (eval_fire && res.we);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : row_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : new_line;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eval_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      status_q    <= res.status;
      old_value_q <= res.old_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign old_value_o = old_value_q;

  // Checks
  a_out_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EVAL))
    else $error("result appeared without a probe");

  a_acc_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_EVAL))
    else $error("accepted transaction not probed");

  a_eval_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && !out_valid_q) |=> (state_q == ST_IDLE))
    else $error("probe stalled with free output register");

  a_we_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eval_fire && res.we) |-> (res.status != STAT_PRESENT && res.status != STAT_RANGE))
    else $error("write-back on a non-modifying transaction");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Line-probed value cache testbench
// Drives put and clear transactions into the cache, keeps a shadow copy of
// the value table and the size register, predicts status and old value for
// every accepted transaction and compares each returned result in order.
// Runs a directed opening, then random phases at several table sizes, with
// random idle bursts on both channels except in the final phase.
// ----------------------------------------------------------------------------
module tb_top import lpvc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_LOG2    = DEF_LOG2_MAX_ENTRIES;
  localparam int unsigned TBL_DEPTH   = 1 << TBL_LOG2;
  localparam int unsigned LINE_N      = DEF_LINE_ENTRIES;
  localparam int unsigned RAND_ITEMS  = 192;
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam logic FUNC_PUT   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic              func;
    logic [VAL_W-1:0]  value;
    logic [HASH_W-1:0] hash;
    logic [IDX_W-1:0]  entry_index;
  } cache_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  old_value;
  } cache_outcome_t;

  // DUT connections
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic              func_i        = FUNC_PUT;
  logic [VAL_W-1:0]  value_i       = '0;
  logic [HASH_W-1:0] hash_i        = '0;
  logic [IDX_W-1:0]  entry_index_i = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [VAL_W-1:0]  old_value_o;
  logic              cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i   = '0;

  // Shadow state of the cache
  logic [VAL_W-1:0]  value_mirror [TBL_DEPTH];
  logic [CFG_W-1:0]  size_shadow = SIZE_LOG2_RESET;

  cache_req_t     queued_requests[$];
  cache_outcome_t predicted_outcomes[$];

  int unsigned items_sent   = 0;
  int unsigned items_taken  = 0;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned idle_pct     = 0;
  int unsigned in_gap       = 0;
  int unsigned out_gap      = 0;
  int unsigned hot_base     = 0;
  bit          in_taken     = 1'b0;

  line_probed_value_cache_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .value_i       (value_i),
    .hash_i        (hash_i),
    .entry_index_i (entry_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .old_value_o   (old_value_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 12 ns clock
  always begin
    #6ns clk_i = 1'b1;
    #6ns clk_i = 1'b0;
  end

  // Entries in use: saturate at the table depth, never below one line
  function automatic int unsigned entries_for(logic [CFG_W-1:0] size_log2);
    int unsigned n;
    n = (size_log2 > TBL_LOG2) ? TBL_DEPTH : (1 << size_log2);
    if (n < LINE_N) n = LINE_N;
    return n;
  endfunction

  // Work out the outcome of one transaction and update the shadow table
  function automatic cache_outcome_t cache_lookup_update(cache_req_t req);
    cache_outcome_t res;
    int unsigned    entries;
    logic [IDX_W-1:0] start, slot;
    bit             done;
    entries = entries_for(size_shadow);
    res.status    = STAT_PRESENT;
    res.old_value = '0;
    done = 1'b0;
    if (req.func == FUNC_CLEAR) begin
      if (req.entry_index >= entries) begin
        res.status = STAT_RANGE;
      end else begin
        res.old_value = value_mirror[req.entry_index];
        value_mirror[req.entry_index] = '0;
        res.status = STAT_CLEARED;
      end
    end else begin
      start = req.hash[IDX_W-1:0] & IDX_W'(entries - 1);
      slot  = start;
      // walk the line from the start slot, wrapping inside it
      for (int k = 0; k < LINE_N && !done; k++) begin
        if (value_mirror[slot] == '0) begin
          value_mirror[slot] = req.value;
          res.status = STAT_INSERTED;
          done = 1'b1;
        end else if (value_mirror[slot] == req.value) begin
          res.status = STAT_PRESENT;
          done = 1'b1;
        end else begin
          slot = (slot & ~IDX_W'(LINE_N - 1)) | ((slot + 1'b1) & IDX_W'(LINE_N - 1));
        end
      end
      // line full: evict the start slot
      if (!done) begin
        res.old_value = value_mirror[start];
        value_mirror[start] = req.value;
        res.status = STAT_REPLACED;
      end
    end
    return res;
  endfunction

  // Random transaction, mostly aimed at a couple of hot lines so they fill up
  function automatic cache_req_t random_request(int unsigned entries);
    cache_req_t  req;
    int unsigned pick, hot_lines, slot;
    hot_lines = (entries / LINE_N > 1) ? 2 : 1;
    slot = hot_base * LINE_N + $urandom_range(0, hot_lines * LINE_N - 1);
    req.value       = $urandom;
    req.hash        = $urandom;
    req.entry_index = IDX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      req.func = FUNC_PUT;
      pick = $urandom_range(0, 99);
      if (pick < 10) req.value = '0;
      else if (pick < 75) req.value = $urandom_range(1, 40);
      if ($urandom_range(0, 4) != 0)
        req.hash = (req.hash & ~HASH_W'(entries - 1)) | HASH_W'(slot);
    end else if (pick < 90) begin
      req.func = FUNC_CLEAR;
      req.entry_index = IDX_W'(slot);
    end else begin
      req.func = FUNC_CLEAR;
    end
    return req;
  endfunction

  function automatic cache_req_t make_req(logic f, logic [VAL_W-1:0] v,
                                          logic [HASH_W-1:0] h, logic [IDX_W-1:0] e);
    cache_req_t req;
    req.func = f;
    req.value = v;
    req.hash = h;
    req.entry_index = e;
    return req;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Input driver: holds a transaction until accepted, idles in random bursts
  always @(negedge clk_i) begin : drive_requests
    cache_req_t nxt;
    if (!in_valid_i || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (queued_requests.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        in_gap = $urandom_range(0, 3);
        in_valid_i <= 1'b0;
      end else begin
        nxt = queued_requests.pop_front();
        func_i        <= nxt.func;
        value_i       <= nxt.value;
        hash_i        <= nxt.hash;
        entry_index_i <= nxt.entry_index;
        in_valid_i    <= 1'b1;
      end
    end
    in_taken = 1'b0;
  end

  // Output side back-pressure in random bursts
  always @(negedge clk_i) begin : drive_result_ready
    if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_gap = $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: track config writes, predict on acceptance, check results
  always @(posedge clk_i) begin : watch_channels
    cache_req_t     req;
    cache_outcome_t want;
    cycle_count++;
    if (rst_ni) begin
      if (cfg_we_i) size_shadow = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        req = make_req(func_i, value_i, hash_i, entry_index_i);
        predicted_outcomes.push_back(cache_lookup_update(req));
        in_taken = 1'b1;
        items_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (predicted_outcomes.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d old=%h",
                                    status_o, old_value_o));
        end else begin
          want = predicted_outcomes.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
          if (old_value_o !== want.old_value)
            report_mismatch($sformatf("old_value got %h want %h",
                                      old_value_o, want.old_value));
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus and phase control
  initial begin : run_phases
    logic [CFG_W-1:0] size_plan [9];
    int unsigned      entries;
    size_plan = '{4'd12, 4'd4, 4'd15, 4'd0, 4'd5, 4'd8, 4'd13, 4'd6, 4'd12};
    for (int i = 0; i < TBL_DEPTH; i++) value_mirror[i] = '0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening at the reset size
    for (int v = 1; v <= 16; v++)
      queued_requests.push_back(make_req(FUNC_PUT, VAL_W'(v), '0, '0));     // fill line 0
    queued_requests.push_back(make_req(FUNC_PUT, 32'd17, 32'd5, '0));       // full line, evict
    queued_requests.push_back(make_req(FUNC_PUT, 32'd10, 32'd9, '0));       // already present
    queued_requests.push_back(make_req(FUNC_PUT, '0, 32'd3, '0));           // zero on full line
    queued_requests.push_back(make_req(FUNC_CLEAR, '0, '0, 12'd5));
    queued_requests.push_back(make_req(FUNC_CLEAR, '0, '0, 12'd5));         // clear empty entry
    queued_requests.push_back(make_req(FUNC_PUT, '1, '1, '1));              // top slot
    queued_requests.push_back(make_req(FUNC_PUT, 32'd7, '1, '0));           // wraps in line
    queued_requests.push_back(make_req(FUNC_CLEAR, '1, '1, '1));
    items_sent += queued_requests.size();

    foreach (size_plan[p]) begin
      if (p > 0) begin
        while (items_taken != items_sent || predicted_outcomes.size() != 0)
          @(posedge clk_i);
        repeat (4) @(posedge clk_i);
        @(negedge clk_i);
        cfg_wdata_i <= size_plan[p];
        cfg_we_i    <= 1'b1;
        @(negedge clk_i);
        cfg_we_i    <= 1'b0;
      end
      entries  = entries_for(size_plan[p]);
      hot_base = (entries / LINE_N > 2) ? $urandom_range(0, entries / LINE_N - 2) : 0;
      // last phase runs flat out; others vary the idle rate
      if (p == $size(size_plan) - 1) idle_pct = 0;
      else idle_pct = (p % 3 == 0) ? 5 : ((p % 3 == 1) ? 25 : 12);
      // clears just inside and beyond the size in use
      if (size_plan[p] == 4'd4) begin
        queued_requests.push_back(make_req(FUNC_CLEAR, '0, '0, 12'd16));
        queued_requests.push_back(make_req(FUNC_CLEAR, '0, '0, 12'd4095));
        queued_requests.push_back(make_req(FUNC_CLEAR, '0, '0, 12'd15));
        items_sent += 3;
      end
      for (int n = 0; n < RAND_ITEMS; n++) begin
        queued_requests.push_back(random_request(entries));
        items_sent++;
      end
    end

    while (items_taken != items_sent || predicted_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
